>>> design/tcce_pkg.sv
// Package for the text console cursor engine.
// Holds the command and character codes, cell widths and the controller states.
// No dependencies.
package tcce_pkg;

  localparam int unsigned CellW = 16;
  localparam int unsigned CharW = 8;
  localparam int unsigned AttrW = 8;
  localparam int unsigned CmdW  = 2;

  localparam logic [CmdW-1:0] CmdPut   = 2'd0;
  localparam logic [CmdW-1:0] CmdClear = 2'd1;
  localparam logic [CmdW-1:0] CmdRead  = 2'd2;

  localparam logic [CharW-1:0] CharBs    = 8'h08;
  localparam logic [CharW-1:0] CharTab   = 8'h09;
  localparam logic [CharW-1:0] CharLf    = 8'h0A;
  localparam logic [CharW-1:0] CharCr    = 8'h0D;
  localparam logic [CharW-1:0] CharSpace = 8'h20;
  localparam logic [CharW-1:0] CharLast  = 8'h7F;

  localparam logic [AttrW-1:0] AttrReset = 8'h0F;

  typedef enum logic [2:0] {
    StInit,
    StIdle,
    StRead,
    StScroll,
    StFill,
    StEmit
  } state_e;

endpackage

>>> design/text_console_cursor_engine.sv
// Top level of the text console cursor engine: screen memory, cursor and sequencer.
// Depends on tcce_pkg.
//
// Channel   Direction  Handshake                  Word
// cfg       in         cfg_we_i                   cfg_wdata_i (text attribute)
// in        in         in_valid_i / in_stall_o    cmd_i, char_code_i, cell_index_i
// out       out        out_valid_o / out_stall_i  cursor_col_o, cursor_row_o,
//                                                 cursor_location_o, cell_value_o
//
// A put passes through StEmit to its result; a read of a cell on the screen passes through StRead, then StEmit.
// A put that runs past the last row scrolls through the single memory port pair: it
// copies each cell from index COLUMNS on up by one row, then blanks the last row.
// A clear writes one cell a cycle over all ROWS*COLUMNS cells.
// After reset all ROWS*COLUMNS cells are blanked while in_stall_o is high.
// The output register holds a word under stall while the next word is accepted.
module text_console_cursor_engine #(
  parameter int unsigned COLUMNS   = 80,
  parameter int unsigned ROWS      = 25,
  parameter int unsigned TAB_WIDTH = 8,
  localparam int unsigned CellCount = COLUMNS * ROWS,
  localparam int unsigned ColW      = $clog2(COLUMNS),
  localparam int unsigned RowW      = $clog2(ROWS),
  localparam int unsigned IdxW      = $clog2(CellCount)
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [tcce_pkg::AttrW-1:0]     cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [tcce_pkg::CmdW-1:0]      cmd_i,
  input  logic [tcce_pkg::CharW-1:0]     char_code_i,
  input  logic [IdxW-1:0]                cell_index_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [ColW-1:0]                cursor_col_o,
  output logic [RowW-1:0]                cursor_row_o,
  output logic [IdxW-1:0]                cursor_location_o,
  output logic [tcce_pkg::CellW-1:0]     cell_value_o
);

  localparam int unsigned ColNxtW = $clog2(COLUMNS + TAB_WIDTH + 1);
  localparam int unsigned RowNxtW = RowW + 1;
  localparam int unsigned TabW    = $clog2(TAB_WIDTH);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(CellCount - 1);

  tcce_pkg::state_e state_q, state_d;

  logic [tcce_pkg::AttrW-1:0] attr_q;
  logic [ColW-1:0]            col_q;
  logic [RowW-1:0]            row_q;
  logic [TabW-1:0]            phase_q;
  logic [IdxW-1:0]            rd_ptr_q;
  logic [IdxW-1:0]            wr_ptr_q;
  logic                       rd_done_q;
  logic                       cp_valid_q;
  logic [tcce_pkg::CellW-1:0] value_q;

  logic [tcce_pkg::CellW-1:0] mem [CellCount];
  logic [tcce_pkg::CellW-1:0] rd_data_q;

  logic                       out_valid_q;
  logic [ColW-1:0]            out_col_q;
  logic [RowW-1:0]            out_row_q;
  logic [IdxW-1:0]            out_loc_q;
  logic [tcce_pkg::CellW-1:0] out_value_q;

  logic                       in_accept;
  logic [IdxW-1:0]            cur_loc;
  logic                       rd_in_range;

  logic [ColNxtW-1:0]         col_ext;
  logic [ColNxtW-1:0]         col_n;
  logic [RowNxtW-1:0]         row_n;
  logic [TabW-1:0]            phase_n;
  logic                       put_write;
  logic                       scroll_need;

  logic                       mem_we;
  logic [IdxW-1:0]            mem_waddr;
  logic [tcce_pkg::CellW-1:0] mem_wdata;
  logic                       mem_re;
  logic [IdxW-1:0]            mem_raddr;
  logic                       out_load;

  assign in_stall_o  = (state_q != tcce_pkg::StIdle);
  assign in_accept   = in_valid_i && !in_stall_o;
  assign cur_loc     = IdxW'(IdxW'(row_q) * IdxW'(COLUMNS)) + IdxW'(col_q);
  assign rd_in_range = {1'b0, cell_index_i} < (IdxW + 1)'(CellCount);

  assign out_valid_o       = out_valid_q;
  assign cursor_col_o      = out_col_q;
  assign cursor_row_o      = out_row_q;
  assign cursor_location_o = out_loc_q;
  assign cell_value_o      = out_value_q;

  // Cursor movement for one put character, before scrolling.
  always_comb begin
    col_ext   = ColNxtW'(col_q);
    col_n     = col_ext;
    row_n     = RowNxtW'(row_q);
    phase_n   = phase_q;
    put_write = 1'b0;
    case (char_code_i)
      tcce_pkg::CharBs: begin
        if (col_q != '0) begin
          col_n   = col_ext - 1'b1;
          phase_n = (phase_q == '0) ? TabW'(TAB_WIDTH - 1) : phase_q - 1'b1;
        end
      end
      tcce_pkg::CharTab: begin
        col_n   = col_ext + ColNxtW'(TAB_WIDTH) - ColNxtW'(phase_q);
        phase_n = '0;
      end
      tcce_pkg::CharCr: begin
        col_n   = '0;
        phase_n = '0;
      end
      tcce_pkg::CharLf: begin
        col_n   = '0;
        phase_n = '0;
        row_n   = row_n + 1'b1;
      end
      default: begin
        if (char_code_i inside {[tcce_pkg::CharSpace:tcce_pkg::CharLast]}) begin
          put_write = 1'b1;
          col_n     = col_ext + 1'b1;
          phase_n   = (phase_q == TabW'(TAB_WIDTH - 1)) ? '0 : phase_q + 1'b1;
        end
      end
    endcase
    if (col_n >= ColNxtW'(COLUMNS)) begin
      col_n   = '0;
      phase_n = '0;
      row_n   = row_n + 1'b1;
    end
    scroll_need = (row_n >= RowNxtW'(ROWS));
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      tcce_pkg::StInit: begin
        if (wr_ptr_q == LastIdx) state_d = tcce_pkg::StIdle;
      end
      tcce_pkg::StIdle: begin
        if (in_accept) begin
          case (cmd_i)
            tcce_pkg::CmdPut:   state_d = scroll_need ? tcce_pkg::StScroll : tcce_pkg::StEmit;
            tcce_pkg::CmdClear: state_d = tcce_pkg::StFill;
            tcce_pkg::CmdRead:  state_d = rd_in_range ? tcce_pkg::StRead : tcce_pkg::StEmit;
            default:            state_d = tcce_pkg::StEmit;
          endcase
        end
      end
      tcce_pkg::StRead:   state_d = tcce_pkg::StEmit;
      tcce_pkg::StScroll: begin
        if (rd_done_q && cp_valid_q) state_d = tcce_pkg::StFill;
      end
      tcce_pkg::StFill: begin
        if (wr_ptr_q == LastIdx) state_d = tcce_pkg::StEmit;
      end
      tcce_pkg::StEmit: begin
        if (!out_valid_q || !out_stall_i) state_d = tcce_pkg::StIdle;
      end
      default: state_d = tcce_pkg::StIdle;
    endcase
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = wr_ptr_q;
    mem_wdata = {attr_q, tcce_pkg::CharSpace};
    mem_re    = 1'b0;
    mem_raddr = rd_ptr_q;
    out_load  = 1'b0;
    case (state_q)
      tcce_pkg::StInit: begin
        mem_we    = 1'b1;
        mem_wdata = {tcce_pkg::AttrReset, tcce_pkg::CharSpace};
      end
      tcce_pkg::StIdle: begin
        if (in_accept && cmd_i == tcce_pkg::CmdPut && put_write) begin
          mem_we    = 1'b1;
          mem_waddr = cur_loc;
          mem_wdata = {attr_q, char_code_i};
        end
        if (in_accept && cmd_i == tcce_pkg::CmdRead && rd_in_range) begin
          mem_re    = 1'b1;
          mem_raddr = cell_index_i;
        end
      end
      tcce_pkg::StScroll: begin
        mem_re    = !rd_done_q;
        mem_we    = cp_valid_q;
        mem_wdata = rd_data_q;
      end
      tcce_pkg::StFill: mem_we = 1'b1;
      tcce_pkg::StEmit: out_load = !out_valid_q || !out_stall_i;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mem_re) rd_data_q <= mem[mem_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tcce_pkg::StInit;
      attr_q      <= tcce_pkg::AttrReset;
      col_q       <= '0;
      row_q       <= '0;
      phase_q     <= '0;
      rd_ptr_q    <= '0;
      wr_ptr_q    <= '0;
      rd_done_q   <= 1'b0;
      cp_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      cp_valid_q <= mem_re && (state_q == tcce_pkg::StScroll);
      if (cfg_we_i) attr_q <= cfg_wdata_i;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        tcce_pkg::StInit, tcce_pkg::StFill: wr_ptr_q <= wr_ptr_q + 1'b1;
        tcce_pkg::StIdle: begin
          if (in_accept && cmd_i == tcce_pkg::CmdPut) begin
            col_q   <= ColW'(col_n);
            phase_q <= phase_n;
            if (scroll_need) begin
              row_q     <= RowW'(ROWS - 1);
              rd_ptr_q  <= IdxW'(COLUMNS);
              wr_ptr_q  <= '0;
              rd_done_q <= 1'b0;
            end else begin
              row_q <= RowW'(row_n);
            end
          end
          if (in_accept && cmd_i == tcce_pkg::CmdClear) begin
            col_q    <= '0;
            row_q    <= '0;
            phase_q  <= '0;
            wr_ptr_q <= '0;
          end
        end
        tcce_pkg::StScroll: begin
          if (mem_re) begin
            rd_done_q <= (rd_ptr_q == LastIdx);
            if (rd_ptr_q != LastIdx) rd_ptr_q <= rd_ptr_q + 1'b1;
          end
          if (mem_we) wr_ptr_q <= wr_ptr_q + 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == tcce_pkg::StIdle && in_accept) value_q <= '0;
    else if (state_q == tcce_pkg::StRead) value_q <= rd_data_q;
    if (out_load) begin
      out_col_q   <= col_q;
      out_row_q   <= row_q;
      out_loc_q   <= cur_loc;
      out_value_q <= value_q;
    end
  end

  a_cursor_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (RowNxtW'(row_q) < RowNxtW'(ROWS)) && (ColNxtW'(col_q) < ColNxtW'(COLUMNS)))
    else $error("Cursor left the screen.");

  a_scroll_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == tcce_pkg::StScroll) |-> (wr_ptr_q < rd_ptr_q))
    else $error("Scroll write caught up with its read.");

  a_read_path: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && cmd_i == tcce_pkg::CmdRead && rd_in_range) |=>
      (state_q == tcce_pkg::StRead))
    else $error("Cell read did not wait for memory data.");

  a_emit_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == tcce_pkg::StEmit && !(out_valid_q && out_stall_i)) |=>
      (out_valid_q && state_q == tcce_pkg::StIdle))
    else $error("Result word was not presented.");

endmodule
